// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the port checker of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition in a cycle that implies a property in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/cdra_pkg.sv =====
// ---------------------------------------------------------------------------
// CAN FD data rate selector package
// Request and result types, register indexes, operation codes and the
// data-phase timing table.
// ---------------------------------------------------------------------------
package cdra_pkg;

    // Timing table size; the used count is capped at the defined rows.
    localparam int TABLE_ENTRIES   = 4;
    localparam int DEFINED_ENTRIES = 4;
    localparam int USED_ENTRIES    = (TABLE_ENTRIES > DEFINED_ENTRIES) ? DEFINED_ENTRIES :
                                     ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
    localparam logic [2:0] USED_CNT = 3'(USED_ENTRIES);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SETTINGS_VALID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETUNE_THRESHOLD = 2'd2;
    localparam logic [15:0]          THRESHOLD_RESET      = 16'd32;
    localparam logic [15:0]          STREAK_MAX           = 16'hFFFF;

    // Operation codes of a request.
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_ERROR   = 2'd2;
    localparam logic [1:0] OP_SERVICE = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic       frame_is_fd;
        logic [7:0] error_log_count;
    } t_in;

    typedef struct packed {
        logic [1:0] rate_index;
        logic [2:0] rate_mbps;
        logic [4:0] prescaler_minus_one;
        logic [4:0] seg1_minus_one;
        logic [3:0] seg2_minus_one;
        logic [3:0] sjw_minus_one;
        logic       timing_changed;
        logic       auto_mode;
        logic       rate_locked;
        logic       classic_seen;
        logic       retune_pending;
    } t_out;

    typedef struct packed {
        logic        settings_valid;
        logic [7:0]  requested_rate_mbps;
        logic [15:0] retune_threshold;
    } t_cfg;

    // One row of data-phase timing, real (not minus one) values.
    typedef struct packed {
        logic [2:0] mbps;
        logic [4:0] presc;
        logic [4:0] seg1;
        logic [3:0] seg2;
        logic [3:0] sjw;
    } t_timing_row;

    localparam t_timing_row RATE_TABLE [DEFINED_ENTRIES] = '{
        '{mbps: 3'd5, presc: 5'd1, seg1: 5'd11, seg2: 4'd4, sjw: 4'd4},
        '{mbps: 3'd4, presc: 5'd1, seg1: 5'd14, seg2: 4'd5, sjw: 4'd5},
        '{mbps: 3'd2, presc: 5'd2, seg1: 5'd14, seg2: 4'd5, sjw: 4'd5},
        '{mbps: 3'd1, presc: 5'd4, seg1: 5'd14, seg2: 4'd5, sjw: 4'd5}
    };

endpackage

// ===== rtl/core/cdra_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the settings-valid flag, the requested rate and the retune
// threshold, written through a plain write port.
// ---------------------------------------------------------------------------
module cdra_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdra_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cdra_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output cdra_pkg::t_cfg                      o_cfg
);

    logic        r_settings_valid;
    logic [7:0]  r_requested_rate;
    logic [15:0] r_retune_threshold;

    // Register writes; an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settings_valid   <= 1'b0;
            r_requested_rate   <= 8'd0;
            r_retune_threshold <= cdra_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cdra_pkg::REG_SETTINGS_VALID:   r_settings_valid   <= i_cfg_data[0];
                cdra_pkg::REG_REQUESTED_RATE:   r_requested_rate   <= i_cfg_data[7:0];
                cdra_pkg::REG_RETUNE_THRESHOLD: r_retune_threshold <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.settings_valid      = r_settings_valid;
    assign o_cfg.requested_rate_mbps = r_requested_rate;
    assign o_cfg.retune_threshold    = r_retune_threshold;

endmodule

// ===== rtl/core/cdra_core.sv =====
// ---------------------------------------------------------------------------
// Rate selection state and result logic
// Keeps the rate index, mode flags, error streak and retune request, and
// forms the result of the request held in the input register.
// ---------------------------------------------------------------------------
module cdra_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  cdra_pkg::t_in   i_item,
    input  cdra_pkg::t_cfg  i_cfg,
    output cdra_pkg::t_out  o_result
);

    logic [1:0]  r_index;
    logic        r_auto;
    logic        r_locked;
    logic        r_classic;
    logic [15:0] r_streak;
    logic        r_retune;

    logic [1:0]  n_index;
    logic        n_auto;
    logic        n_locked;
    logic        n_classic;
    logic [15:0] n_streak;
    logic        n_retune;
    logic        changed;

    logic [7:0]  want;
    logic        found;
    logic [1:0]  hit;
    logic [15:0] streak_inc;
    logic        searching;
    logic [2:0]  index_plus;
    logic [1:0]  out_index;
    cdra_pkg::t_timing_row row;

    // Search the used table rows for the requested rate, first match wins.
    always_comb begin
        want  = i_cfg.settings_valid ? i_cfg.requested_rate_mbps : 8'd0;
        found = 1'b0;
        hit   = 2'd0;
        for (int i = 0; i < cdra_pkg::USED_ENTRIES; i++) begin
            if (!found && ({5'd0, cdra_pkg::RATE_TABLE[i].mbps} == want)) begin
                found = 1'b1;
                hit   = 2'(i);
            end
        end
    end

    // Auto search is active only in auto mode with nothing locking it.
    assign searching  = r_auto && !r_locked && !r_classic;
    assign streak_inc = (r_streak != cdra_pkg::STREAK_MAX) ? r_streak + 16'd1 : r_streak;
    assign index_plus = {1'b0, r_index} + 3'd1;

    // Next state for the current request.
    always_comb begin
        n_index   = r_index;
        n_auto    = r_auto;
        n_locked  = r_locked;
        n_classic = r_classic;
        n_streak  = r_streak;
        n_retune  = r_retune;
        changed   = 1'b0;
        case (i_item.operation)
            cdra_pkg::OP_START: begin
                if (want == 8'd0 || !found) begin
                    n_auto   = 1'b1;
                    n_locked = 1'b0;
                    n_index  = 2'd0;
                end else begin
                    n_auto   = 1'b0;
                    n_locked = 1'b1;
                    n_index  = hit;
                end
                n_classic = 1'b0;
                n_streak  = 16'd0;
                n_retune  = 1'b0;
                changed   = 1'b1;
            end
            cdra_pkg::OP_FRAME: begin
                n_streak = 16'd0;
                if (i_item.frame_is_fd) begin
                    n_locked = 1'b1;
                end else begin
                    n_classic = 1'b1;
                end
            end
            cdra_pkg::OP_ERROR: begin
                if (i_item.error_log_count != 8'd0 && searching) begin
                    if (streak_inc >= i_cfg.retune_threshold) begin
                        n_retune = 1'b1;
                        n_streak = 16'd0;
                    end else begin
                        n_streak = streak_inc;
                    end
                end
            end
            cdra_pkg::OP_SERVICE: begin
                if (r_retune && searching) begin
                    n_index = (index_plus >= cdra_pkg::USED_CNT) ? 2'd0 : index_plus[1:0];
                    changed = 1'b1;
                end
                n_retune = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // State registers advance only when the request moves to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= 2'd0;
            r_auto    <= 1'b0;
            r_locked  <= 1'b0;
            r_classic <= 1'b0;
            r_streak  <= 16'd0;
            r_retune  <= 1'b0;
        end else if (i_fire) begin
            r_index   <= out_index;
            r_auto    <= n_auto;
            r_locked  <= n_locked;
            r_classic <= n_classic;
            r_streak  <= n_streak;
            r_retune  <= n_retune;
        end
    end

    // Result fields from the new state and the timing table.
    assign out_index = ({1'b0, n_index} >= cdra_pkg::USED_CNT) ? 2'd0 : n_index;
    assign row       = cdra_pkg::RATE_TABLE[out_index];

    assign o_result.rate_index          = out_index;
    assign o_result.rate_mbps           = row.mbps;
    assign o_result.prescaler_minus_one = row.presc - 5'd1;
    assign o_result.seg1_minus_one      = row.seg1 - 5'd1;
    assign o_result.seg2_minus_one      = row.seg2 - 4'd1;
    assign o_result.sjw_minus_one       = row.sjw - 4'd1;
    assign o_result.timing_changed      = changed;
    assign o_result.auto_mode           = n_auto;
    assign o_result.rate_locked         = n_locked;
    assign o_result.classic_seen        = n_classic;
    assign o_result.retune_pending      = n_retune;

endmodule

// ===== rtl/core/canfd_data_rate_autoselect.sv =====
// ---------------------------------------------------------------------------
// CAN FD data rate selector, top level
// Picks the CAN FD data-phase timing set from start, frame, error and
// service requests and reports the timing fields and mode flags.
// ---------------------------------------------------------------------------
// Usage:
// Requests enter on i_in with i_in_valid / o_in_ready and each one gives
// exactly one result on o_out with o_out_valid / i_out_ready.
// A request is captured in the input register, and its result then moves
// into the result register when that register is free or drains, which
// raises o_out_valid. One request per cycle is taken for as long as results
// are drained; the state update is a single pass of flag logic and one
// 16-bit increment and compare between the two registers.
// When the receiver stalls, the result register holds its value, one more
// request waits in the input register, and o_in_ready then falls.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data while no request is in flight; an index past the last
// register is ignored.
// Reset (i_rst_n low at a clock edge) empties both registers, clears all
// mode flags, the rate index and the error streak, and restores the
// register defaults (threshold 32). No clearing pass is needed.
// ---------------------------------------------------------------------------
module canfd_data_rate_autoselect (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cdra_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cdra_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [cdra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cdra_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cdra_pkg::t_cfg cfg;
    cdra_pkg::t_out result;

    logic            r_in_valid;
    cdra_pkg::t_in   r_in;
    logic            r_out_valid;
    cdra_pkg::t_out  r_out;
    logic            advance;

    cdra_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cdra_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The held request moves on when the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/cdra_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker for the CAN FD data rate selector
// Watches the top-level ports for result stability and for consistent
// mode flags and timing fields.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdra_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  cdra_pkg::t_out                   o_out
);

    logic stalled;
    logic rate_ok;
    logic pend_ok;
    logic pin_ok;

    assign stalled = o_out_valid && !i_out_ready;

    // Each table entry has one fixed rate.
    assign rate_ok = (o_out.rate_index == 2'd0 && o_out.rate_mbps == 3'd5)
                  || (o_out.rate_index == 2'd1 && o_out.rate_mbps == 3'd4)
                  || (o_out.rate_index == 2'd2 && o_out.rate_mbps == 3'd2)
                  || (o_out.rate_index == 2'd3 && o_out.rate_mbps == 3'd1);

    // A retune can only be pending while the rate is auto-detected.
    assign pend_ok = !o_out.retune_pending || o_out.auto_mode;

    // New timing outside auto mode comes only from a pinned, locked rate.
    assign pin_ok = !(o_out.timing_changed && !o_out.auto_mode) || o_out.rate_locked;

    // A stalled result stays and keeps its value.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(o_out), "result moved")

    // The reported rate always belongs to the reported table entry.
    `ASSERT_AT(a_rate_match, i_clk, i_rst_n, o_out_valid |-> rate_ok, "rate does not match index")

    // Flag consistency of every valid result.
    `ASSERT_AT(a_retune_auto, i_clk, i_rst_n, o_out_valid |-> pend_ok, "retune outside auto mode")
    `ASSERT_AT(a_pin_locks, i_clk, i_rst_n, o_out_valid |-> pin_ok, "pinned timing without lock")

endmodule

bind canfd_data_rate_autoselect cdra_checker u_checker (.*);

// ===== verif/cdra_rate_checker.sv =====
// ---------------------------------------------------------------------------
// CAN FD data rate selector checker
// Watches the request, result and register ports, keeps its own copy of the
// selector state, predicts one result per accepted request and compares
// every accepted result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module cdra_rate_checker
    import cdra_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  t_in                     i_in,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  t_out                    i_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    // Register copies.
    logic        cfg_settings_valid;
    logic [7:0]  cfg_rate;
    logic [15:0] cfg_threshold;

    // Selector state.
    logic [1:0]  sel_index;
    logic        auto_on;
    logic        locked_on;
    logic        classic_on;
    logic [15:0] err_streak;
    logic        retune_req;

    // Predicted results, oldest first.
    t_out        expected_rates[$];

    // Flags one mismatching field and counts it.
    function automatic void check_field(string field, int unsigned expv, int unsigned actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, actual %0d", field, expv, actv);
            o_fail_count++;
        end
    endfunction

    // Updates the selector state for one request and returns its result.
    function automatic t_out apply_request(t_in req);
        int          want;
        int          hit;
        bit          found;
        bit          changed;
        t_timing_row row;
        t_out        res;

        found   = 1'b0;
        hit     = 0;
        changed = 1'b0;
        case (req.operation)
            OP_START: begin
                want = cfg_settings_valid ? int'(cfg_rate) : 0;
                for (int i = 0; i < USED_ENTRIES; i++) begin
                    if (!found && int'(RATE_TABLE[i].mbps) == want) begin
                        found = 1'b1;
                        hit   = i;
                    end
                end
                if (want == 0 || !found) begin
                    auto_on   = 1'b1;
                    locked_on = 1'b0;
                    sel_index = 2'd0;
                end else begin
                    auto_on   = 1'b0;
                    locked_on = 1'b1;
                    sel_index = 2'(hit);
                end
                classic_on = 1'b0;
                err_streak = 16'd0;
                retune_req = 1'b0;
                changed    = 1'b1;
            end
            OP_FRAME: begin
                err_streak = 16'd0;
                if (req.frame_is_fd) begin
                    locked_on = 1'b1;
                end else begin
                    classic_on = 1'b1;
                end
            end
            OP_ERROR: begin
                // Errors only count while searching in auto mode.
                if (req.error_log_count != 8'd0 && auto_on && !locked_on && !classic_on) begin
                    if (err_streak != STREAK_MAX) begin
                        err_streak = err_streak + 16'd1;
                    end
                    if (err_streak >= cfg_threshold) begin
                        retune_req = 1'b1;
                        err_streak = 16'd0;
                    end
                end
            end
            default: begin
                if (retune_req && auto_on && !locked_on && !classic_on) begin
                    sel_index = 2'((int'(sel_index) + 1) % USED_ENTRIES);
                    changed   = 1'b1;
                end
                retune_req = 1'b0;
            end
        endcase

        if (int'(sel_index) >= USED_ENTRIES) begin
            sel_index = 2'd0;
        end
        row = RATE_TABLE[sel_index];

        res.rate_index          = sel_index;
        res.rate_mbps           = row.mbps;
        res.prescaler_minus_one = 5'(row.presc - 5'd1);
        res.seg1_minus_one      = 5'(row.seg1 - 5'd1);
        res.seg2_minus_one      = 4'(row.seg2 - 4'd1);
        res.sjw_minus_one       = 4'(row.sjw - 4'd1);
        res.timing_changed      = changed;
        res.auto_mode           = auto_on;
        res.rate_locked         = locked_on;
        res.classic_seen        = classic_on;
        res.retune_pending      = retune_req;
        return res;
    endfunction

    // All ports are stable at the falling edge, so what is seen here is what
    // the next rising edge acts on.
    always @(negedge i_clk) begin : watch
        t_out want_rsp;

        if (!i_rst_n) begin
            cfg_settings_valid = 1'b0;
            cfg_rate           = 8'd0;
            cfg_threshold      = THRESHOLD_RESET;
            sel_index          = 2'd0;
            auto_on            = 1'b0;
            locked_on          = 1'b0;
            classic_on         = 1'b0;
            err_streak         = 16'd0;
            retune_req         = 1'b0;
            expected_rates.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SETTINGS_VALID:   cfg_settings_valid = i_cfg_data[0];
                    REG_REQUESTED_RATE:   cfg_rate           = i_cfg_data[7:0];
                    REG_RETUNE_THRESHOLD: cfg_threshold      = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Result side: compare with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_rates.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    o_fail_count++;
                end else begin
                    want_rsp = expected_rates.pop_front();
                    check_field("rate_index", want_rsp.rate_index, i_out.rate_index);
                    check_field("rate_mbps", want_rsp.rate_mbps, i_out.rate_mbps);
                    check_field("prescaler_minus_one", want_rsp.prescaler_minus_one,
                                i_out.prescaler_minus_one);
                    check_field("seg1_minus_one", want_rsp.seg1_minus_one,
                                i_out.seg1_minus_one);
                    check_field("seg2_minus_one", want_rsp.seg2_minus_one,
                                i_out.seg2_minus_one);
                    check_field("sjw_minus_one", want_rsp.sjw_minus_one, i_out.sjw_minus_one);
                    check_field("timing_changed", want_rsp.timing_changed,
                                i_out.timing_changed);
                    check_field("auto_mode", want_rsp.auto_mode, i_out.auto_mode);
                    check_field("rate_locked", want_rsp.rate_locked, i_out.rate_locked);
                    check_field("classic_seen", want_rsp.classic_seen, i_out.classic_seen);
                    check_field("retune_pending", want_rsp.retune_pending,
                                i_out.retune_pending);
                end
            end

            // Request side: predict its result.
            if (i_in_valid && i_in_ready) begin
                expected_rates.push_back(apply_request(i_in));
            end
        end
        o_pending = expected_rates.size();
    end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// CAN FD data rate selector testbench
// Drives directed and random start, frame, error and service requests
// through several register settings, with bursty requests and a stalling
// receiver, and reports the verdict from the checker's failure and pending counts.
// ---------------------------------------------------------------------------
module testbench;
    import cdra_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 2000;

    // Receiver stall behaviors.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PATTERN
    } t_rx_mode;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_req    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_SETTINGS_VALID;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    fail_count;
    int                    pending;
    int                    burst_left = 0;
    int                    idle_cycles = 0;
    int                    random_sent = 0;

    t_rx_mode              rx_mode    = RX_FREE;
    int                    rx_left    = 0;
    logic [7:0]            rx_pattern = 8'hA5;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    canfd_data_rate_autoselect u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    cdra_rate_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: each stretch picks a stall behavior of random length.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode    <= t_rx_mode'($urandom_range(0, 3));
            rx_left    <= $urandom_range(16, 160);
            rx_pattern <= 8'($urandom_range(1, 255));
        end else begin
            rx_left    <= rx_left - 1;
            rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        end
        case (rx_mode)
            RX_FREE:  out_ready <= 1'b1;
            RX_LIGHT: out_ready <= ($urandom_range(0, 9) < 7);
            RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
            default:  out_ready <= rx_pattern[0];
        endcase
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request, inserting a gap between bursts, and returns at
    // the edge that accepts it.
    task automatic send_request(input logic [1:0] op, input logic fd, input logic [7:0] cel);
        int  gap;
        bit  taken;
        t_in req;

        req.operation       = op;
        req.frame_is_fd     = fd;
        req.error_log_count = cel;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= req;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    // Holds off new requests until every predicted result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all three registers; upper data bits of the narrow ones are noise.
    task automatic write_config(input logic valid, input logic [7:0] rate,
                                input logic [15:0] threshold);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_SETTINGS_VALID;
        cfg_data <= {15'($urandom), valid};
        @(posedge clk);
        cfg_idx  <= REG_REQUESTED_RATE;
        cfg_data <= {8'($urandom), rate};
        @(posedge clk);
        cfg_idx  <= REG_RETUNE_THRESHOLD;
        cfg_data <= threshold;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random request, weighted toward error samples and service.
    task automatic send_random_request();
        int         roll;
        logic [7:0] cel;

        roll = $urandom_range(0, 99);
        cel  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        if (roll < 3) begin
            send_request(OP_START, 1'($urandom), 8'($urandom));
        end else if (roll < 10) begin
            send_request(OP_FRAME, 1'($urandom), 8'($urandom));
        end else if (roll < 65) begin
            send_request(OP_ERROR, 1'($urandom), cel);
        end else begin
            send_request(OP_SERVICE, 1'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int         phase_len;
        int         pause_at;
        logic [7:0] rate;
        logic [15:0] threshold;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Before any start: errors and service change nothing, frames set flags.
        send_request(OP_ERROR, 1'b1, 8'hFF);
        send_request(OP_SERVICE, 1'b0, 8'h00);
        send_request(OP_FRAME, 1'b1, 8'hFF);
        send_request(OP_FRAME, 1'b0, 8'h00);
        wait_drained();

        // Each supported rate pinned; locked so errors and service do nothing.
        write_config(1'b1, 8'd5, 16'd1);
        send_request(OP_START, 1'b0, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'h01);
        send_request(OP_SERVICE, 1'b0, 8'h00);
        wait_drained();
        write_config(1'b1, 8'd4, 16'd1);
        send_request(OP_START, 1'b1, 8'hFF);
        wait_drained();
        write_config(1'b1, 8'd2, 16'd1);
        send_request(OP_START, 1'b0, 8'h00);
        wait_drained();
        write_config(1'b1, 8'd1, 16'd1);
        send_request(OP_START, 1'b0, 8'h00);
        wait_drained();

        // Settings not valid: auto mode, retune on every counted error.
        write_config(1'b0, 8'd4, 16'd1);
        send_request(OP_START, 1'b0, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'h80);
        send_request(OP_SERVICE, 1'b1, 8'hFF);
        send_request(OP_ERROR, 1'b1, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'h01);
        send_request(OP_FRAME, 1'b0, 8'hFF);
        send_request(OP_SERVICE, 1'b0, 8'h00);
        wait_drained();

        // Unsupported rate with a zero threshold, then an FD frame locks.
        write_config(1'b1, 8'd3, 16'd0);
        send_request(OP_START, 1'b0, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'h55);
        send_request(OP_SERVICE, 1'b0, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'hAA);
        send_request(OP_FRAME, 1'b1, 8'h00);
        send_request(OP_SERVICE, 1'b0, 8'h00);
        wait_drained();

        // Out-of-table rate, threshold of two.
        write_config(1'b1, 8'd255, 16'd2);
        send_request(OP_START, 1'b0, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'h01);
        send_request(OP_ERROR, 1'b1, 8'h02);
        send_request(OP_SERVICE, 1'b0, 8'h00);
        wait_drained();

        // Largest threshold: a long streak stays below it, so service does nothing.
        write_config(1'b0, 8'd0, 16'hFFFF);
        send_request(OP_START, 1'b0, 8'h00);
        repeat (60) send_request(OP_ERROR, 1'($urandom), 8'($urandom_range(1, 255)));
        send_request(OP_SERVICE, 1'b0, 8'h00);
        send_request(OP_ERROR, 1'b0, 8'hFF);
        wait_drained();

        // Random phases, each under its own register setting.
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       rate = 8'd0;
                1:       rate = 8'd1;
                2:       rate = 8'd2;
                3:       rate = 8'd4;
                4:       rate = 8'd5;
                5:       rate = 8'd3;
                6:       rate = 8'd255;
                default: rate = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0:       threshold = 16'd0;
                1:       threshold = 16'($urandom_range(6, 40));
                2:       threshold = 16'hFFFF;
                default: threshold = 16'($urandom_range(1, 5));
            endcase
            write_config(1'($urandom), rate, threshold);

            phase_len = $urandom_range(20, 120);
            pause_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, phase_len - 1) : -1;
            send_request(OP_START, 1'($urandom), 8'($urandom));
            for (int k = 1; k < phase_len; k++) begin
                if (k == pause_at) begin
                    wait_drained();
                end
                send_random_request();
            end
            random_sent += phase_len;
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
